// ----- hw/rtl/sde_pkg.sv -----
// Shared types and constants of the set difference engine.
`timescale 1ns / 1ps
package sde_pkg;

  localparam int DATA_W        = 64;
  localparam int MAX_ITEMS_DEF = 64;

  // Command queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified input item as handed to the back part.
  typedef struct packed {
    logic              do_store;
    logic              do_run;
    logic [DATA_W-1:0] first_value;
    logic [DATA_W-1:0] second_value;
  } sde_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_CMP,
    ST_FLUSH
  } sde_state_t;

endpackage

// ----- hw/rtl/sde_front.sv -----
// Front part: accepts pairs and classifies them as store, drop and run start.
`timescale 1ns / 1ps
module sde_front #(
  parameter int MAX_ITEMS = sde_pkg::MAX_ITEMS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [2*sde_pkg::DATA_W-1:0] in_tdata,
  input  logic                        in_tlast,
  output logic                        cmd_valid,
  input  logic                        cmd_ready,
  output sde_pkg::sde_cmd_t           cmd
);
  import sde_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             room;
  logic             accept;

  assign in_tready = cmd_ready;
  assign accept    = in_tvalid && cmd_ready;
  assign room      = (count_r < CNT_W'(MAX_ITEMS));

  // Pairs that arrive once the lists are full are dropped, but a final
  // pair still starts the comparison.
  always_comb begin
    cmd.do_store     = room;
    cmd.do_run       = in_tlast;
    cmd.first_value  = in_tdata[DATA_W-1:0];
    cmd.second_value = in_tdata[2*DATA_W-1:DATA_W];
    cmd_valid        = in_tvalid;
    count_nxt        = count_r;
    if (accept) begin
      if (in_tlast) begin
        count_nxt = '0;
      end else if (room) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ----- hw/rtl/sde_queue.sv -----
// Short command queue between the front and back parts.
`timescale 1ns / 1ps
module sde_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  sde_pkg::sde_cmd_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output sde_pkg::sde_cmd_t pop_data
);
  import sde_pkg::*;

  sde_cmd_t          entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              push;
  logic              pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entries_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_ready && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- hw/rtl/sde_back.sv -----
// Back part: list memories, the pairwise compare loop and the result register.
`timescale 1ns / 1ps
module sde_back #(
  parameter int MAX_ITEMS = sde_pkg::MAX_ITEMS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  sde_pkg::sde_cmd_t          cmd,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [sde_pkg::DATA_W-1:0] out_tdata,
  output logic                       out_tlast,
  output logic                       out_tuser
);
  import sde_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  logic [DATA_W-1:0] first_mem  [MAX_ITEMS];
  logic [DATA_W-1:0] second_mem [MAX_ITEMS];

  sde_state_t        state_r;
  sde_state_t        state_nxt;
  logic [CNT_W-1:0]  wp_r;
  logic [CNT_W-1:0]  wp_nxt;
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W-1:0]  n_nxt;
  logic [IDX_W-1:0]  i_r;
  logic [IDX_W-1:0]  i_nxt;
  logic [IDX_W-1:0]  j_r;
  logic [IDX_W-1:0]  j_nxt;
  logic [DATA_W-1:0] f_q_r;
  logic [DATA_W-1:0] s_q_r;
  logic              pend_r;
  logic              pend_nxt;
  logic [DATA_W-1:0] pend_val_r;
  logic [DATA_W-1:0] pend_val_nxt;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_last_r;
  logic              out_empty_r;

  logic              mem_we;
  logic              emit;
  logic [DATA_W-1:0] emit_data;
  logic              emit_last;
  logic              emit_empty;
  logic              out_free;
  logic              eq;
  logic              i_end;
  logic              j_end;
  logic              miss;
  logic              stall;
  logic [CNT_W-1:0]  last_idx;

  assign out_free = !out_valid_r || out_tready;
  assign last_idx = n_r - CNT_W'(1);
  assign eq       = (f_q_r == s_q_r);
  assign i_end    = (CNT_W'(i_r) == last_idx);
  assign j_end    = (CNT_W'(j_r) == last_idx);
  assign miss     = !eq && j_end;
  // A second unmatched element can only be taken once the held one has left.
  assign stall    = miss && pend_r && !out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && cmd.do_run) begin
          state_nxt = ST_PRIME;
        end
      end
      ST_PRIME: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (!stall && (eq || j_end) && i_end) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_ready    = 1'b0;
    mem_we       = 1'b0;
    wp_nxt       = wp_r;
    n_nxt        = n_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    pend_nxt     = pend_r;
    pend_val_nxt = pend_val_r;
    emit         = 1'b0;
    emit_data    = pend_val_r;
    emit_last    = 1'b0;
    emit_empty   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        i_nxt     = '0;
        j_nxt     = '0;
        if (cmd_valid) begin
          mem_we = cmd.do_store;
          if (cmd.do_store) begin
            wp_nxt = wp_r + CNT_W'(1);
          end
          if (cmd.do_run) begin
            n_nxt = cmd.do_store ? wp_r + CNT_W'(1) : wp_r;
          end
        end
      end
      ST_PRIME: begin
        // Holds the read address at zero so the first compare sees
        // the entry written by the final pair.
        i_nxt = '0;
        j_nxt = '0;
      end
      ST_CMP: begin
        if (!stall) begin
          if (miss) begin
            emit         = pend_r;
            pend_nxt     = 1'b1;
            pend_val_nxt = f_q_r;
          end
          if (eq || j_end) begin
            if (!i_end) begin
              i_nxt = i_r + IDX_W'(1);
            end
            j_nxt = '0;
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          emit_empty = !pend_r;
          emit_data  = pend_r ? pend_val_r : '0;
          pend_nxt   = 1'b0;
          wp_nxt     = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // List memories: one write port, read data registered.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      first_mem[wp_r[IDX_W-1:0]]  <= cmd.first_value;
      second_mem[wp_r[IDX_W-1:0]] <= cmd.second_value;
    end
    f_q_r <= first_mem[i_nxt];
    s_q_r <= second_mem[j_nxt];
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    pend_val_r <= pend_val_nxt;
    if (emit) begin
      out_data_r  <= emit_data;
      out_last_r  <= emit_last;
      out_empty_r <= emit_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_empty_r;

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> out_last_r)
    else $error("empty result not flagged last");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= CNT_W'(MAX_ITEMS))
    else $error("list write pointer past capacity");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_r)
    else $error("held result left over after a run");

  a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> ((CNT_W'(i_r) < n_r) && (CNT_W'(j_r) < n_r)))
    else $error("compare index outside stored lists");

  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && out_free) |=> (out_valid_r && out_last_r))
    else $error("run end did not produce a final result");

endmodule

// ----- hw/rtl/set_difference_engine_core.sv -----
// Top level of the set difference engine: front, command queue and back.
//
// Usage: pairs arrive on the in_ stream, one item per pair; in_tlast marks
// the final pair of a run. Up to MAX_ITEMS pairs are stored; later pairs of
// the same run are dropped, but a final pair still starts the comparison.
// Each first-list element with no equal second-list element leaves on the
// out_ stream in original order; out_tlast flags the final result, and a
// run with no such element yields one item with out_tuser (empty) set and
// zero data.
// Throughput: a non-final pair is taken whenever in_tready is high. After the
// final pair, the back part's single compare unit checks one (first, second)
// pair per cycle unless a stalled receiver holds the result register: each
// first element scans second elements until it finds an equal one, after a
// priming step and before a flushing step. An unmatched element is held
// back until the next unmatched element is found or the scan ends, so that
// the final one can be flagged last; it then passes to the result register.
// Reset (rst_n low, synchronous) empties the lists, queue and result
// register. A stalled receiver holds the result register; the compare loop
// waits on it, the queue fills and in_tready falls.
`timescale 1ns / 1ps
module set_difference_engine_core #(
  parameter int MAX_ITEMS = sde_pkg::MAX_ITEMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [2*sde_pkg::DATA_W-1:0] in_tdata,   // [63:0] first_value, [127:64] second_value
  input  logic                         in_tlast,   // last_pair
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [sde_pkg::DATA_W-1:0]   out_tdata,  // [63:0] diff_value
  output logic                         out_tlast,  // is_last
  output logic                         out_tuser   // [0] empty_set
);
  import sde_pkg::*;

  sde_cmd_t front_cmd;
  sde_cmd_t back_cmd;
  logic     front_valid;
  logic     front_ready;
  logic     back_valid;
  logic     back_ready;

  sde_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  sde_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_cmd)
  );

  sde_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (back_valid),
    .cmd_ready  (back_ready),
    .cmd        (back_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
